@@ rtl/lavm_pkg.sv @@
// Shared types, constants and helper functions of the look-at view matrix block.
`default_nettype none
package lavm_pkg;

   localparam int WORD_W = 32;              // Q16.16 word
   localparam int DIFF_W = WORD_W + 1;      // exact center - eye
   localparam int UNIT_W = 20;              // unit components and rounded cross terms
   localparam int MUL_W  = 35;              // shared multiplier operand width
   localparam int PROD_W = 2 * MUL_W;       // product and accumulator width
   localparam int TRN_W  = 37;              // rounded dot products before saturation
   localparam int SR_W   = 51;              // exact f x up in Q32.32
   localparam int MAG_W  = SR_W - 1;        // magnitudes entering normalization
   localparam int CNT_W  = 6;
   localparam logic signed [WORD_W-1:0] ONE_Q16 = 32'sd65536;

   typedef struct packed {
      logic [2:0][WORD_W-1:0] eye;
      logic [2:0][DIFF_W-1:0] dir;
      logic [2:0][WORD_W-1:0] up;
      logic                   zero_dir;
   } lavm_item_type;

   typedef struct packed {
      logic push;
      logic full;
   } lavm_qin_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } lavm_qout_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NLOAD, ST_NSHIFT, ST_SQ, ST_SQWAIT, ST_SQRT, ST_DIV, ST_SCALE,
      ST_SCWAIT, ST_CROSS1, ST_CR1WAIT, ST_CROSS2, ST_CR2WAIT, ST_OUT
   } lavm_state_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_SUMSQ, DST_UNIT0, DST_UNIT1, DST_UNIT2, DST_SR0, DST_SR1, DST_SR2,
      DST_U0, DST_U1, DST_U2, DST_TS, DST_TF, DST_TU
   } lavm_dest_type;

   function automatic logic signed [MUL_W-1:0] ext_unit(input logic signed [UNIT_W-1:0] v);
      return MUL_W'(v);
   endfunction

   function automatic logic signed [MUL_W-1:0] ext_word(input logic signed [WORD_W-1:0] v);
      return MUL_W'(v);
   endfunction

endpackage
`default_nettype wire

@@ rtl/lavm_front.sv @@
// Front part: accepts request items, forms center - eye and flags a zero view direction.
`default_nettype none
module lavm_front (
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [31:0]            req_eye_x,
   input  wire logic signed [31:0]            req_eye_y,
   input  wire logic signed [31:0]            req_eye_z,
   input  wire logic signed [31:0]            req_center_x,
   input  wire logic signed [31:0]            req_center_y,
   input  wire logic signed [31:0]            req_center_z,
   input  wire logic signed [31:0]            req_up_x,
   input  wire logic signed [31:0]            req_up_y,
   input  wire logic signed [31:0]            req_up_z,
   input  wire logic                          q_full,
   output lavm_pkg::lavm_qin_type             q_ctl,
   output lavm_pkg::lavm_item_type            q_item
);
   import lavm_pkg::*;

   logic signed [DIFF_W-1:0] dx, dy, dz;

   always_comb begin
      dx = DIFF_W'(req_center_x) - DIFF_W'(req_eye_x);
      dy = DIFF_W'(req_center_y) - DIFF_W'(req_eye_y);
      dz = DIFF_W'(req_center_z) - DIFF_W'(req_eye_z);
      q_item.eye      = {req_eye_z, req_eye_y, req_eye_x};
      q_item.dir      = {dz, dy, dx};
      q_item.up       = {req_up_z, req_up_y, req_up_x};
      q_item.zero_dir = (dx == '0) && (dy == '0) && (dz == '0);
      busy            = q_full;
      q_ctl.push      = start && !q_full;
      q_ctl.full      = q_full;
   end

endmodule
`default_nettype wire

@@ rtl/lavm_queue.sv @@
// Two-entry item queue between the front and back parts.
`default_nettype none
module lavm_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lavm_pkg::lavm_qin_type  in_ctl,
   input  wire lavm_pkg::lavm_item_type in_item,
   output logic                         full,
   input  wire logic                    pop,
   output lavm_pkg::lavm_qout_type      out_ctl,
   output lavm_pkg::lavm_item_type      out_item
);
   import lavm_pkg::*;

   lavm_item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ in_ctl.push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(in_ctl.push) - 2'(do_pop);
      full      = (count_ff == 2'd2);
      out_ctl.pop   = do_pop;
      out_ctl.empty = (count_ff == 2'd0);
      out_item  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.push) mem_ff[wr_ptr_ff] <= in_item;
   end

endmodule
`default_nettype wire

@@ rtl/lavm_back.sv @@
// Back part: sequencer with a shared multiplier, bit-serial square root and divider.
`default_nettype none
module lavm_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lavm_pkg::lavm_qout_type q_ctl,
   input  wire lavm_pkg::lavm_item_type q_item,
   output logic                         q_pop,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_column_index,
   output logic signed [31:0]           rsp_row0,
   output logic signed [31:0]           rsp_row1,
   output logic signed [31:0]           rsp_row2,
   output logic signed [31:0]           rsp_row3,
   output logic                         rsp_degenerate,
   output logic                         rsp_last_column
);
   import lavm_pkg::*;

   function automatic logic signed [TRN_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] r;
      logic signed [TRN_W-1:0] t;
      mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      r   = (mag + PROD_W'(32768)) >> 16;
      t   = $signed({1'b0, r[TRN_W-2:0]});
      return v[PROD_W-1] ? -t : t;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [TRN_W-1:0] v);
      if (v > TRN_W'(64'sd2147483647)) return 32'sh7fffffff;
      if (v < TRN_W'(-64'sd2147483648)) return 32'sh80000000;
      return v[WORD_W-1:0];
   endfunction

   lavm_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic pass_ff, degen_ff;

   logic signed [WORD_W-1:0] eye_ff [3];
   logic signed [WORD_W-1:0] up_ff  [3];
   logic signed [DIFF_W-1:0] d_ff   [3];
   logic signed [SR_W-1:0]   sr_ff  [3];
   logic [MAG_W-1:0] m_ff [3];
   logic [MAG_W-1:0] mx_ff;
   logic [2:0]       neg_ff;
   logic [61:0]      x_ff;
   logic [62:0]      r_ff;
   logic [31:0]      rem_ff;
   logic [33:0]      q_ff;
   logic signed [UNIT_W-1:0] f_ff [3];
   logic signed [UNIT_W-1:0] s_ff [3];
   logic signed [UNIT_W-1:0] u_ff [3];
   logic signed [TRN_W-1:0]  ts_ff, tu_ff, tf_ff;

   logic signed [PROD_W-1:0] prod_ff, acc_ff, acc_sum, unit_tmp;
   logic p_first_ff, p_neg_ff;
   lavm_dest_type p_dest_ff;

   logic signed [MUL_W-1:0] op_a, op_b;
   logic op_neg, op_first;
   lavm_dest_type op_dest;

   logic signed [SR_W-1:0] vsel [3];
   logic [MAG_W-1:0] mag_ld [3];
   logic [MAG_W-1:0] mx_ld;
   logic [62:0] sq_bit, sq_try;
   logic [32:0] div_try;
   logic [33:0] rec;
   logic [UNIT_W-1:0] unit_q;
   logic signed [UNIT_W-1:0] unit_v;
   logic [1:0] col;

   // Operand magnitudes for the vector about to be normalized, plus square-root and divider trial values.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsel[i]   = pass_ff ? sr_ff[i] : SR_W'(d_ff[i]);
         mag_ld[i] = vsel[i][SR_W-1] ? MAG_W'(-vsel[i]) : MAG_W'(vsel[i]);
      end
      mx_ld = mag_ld[0];
      if (mag_ld[1] > mx_ld) mx_ld = mag_ld[1];
      if (mag_ld[2] > mx_ld) mx_ld = mag_ld[2];
      sq_bit  = 63'(1) << {cnt_ff[4:0], 1'b0};
      sq_try  = r_ff + sq_bit;
      div_try = {rem_ff, 1'b0};
      rec     = 34'(({1'b0, q_ff} + 35'd1) >> 1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (!q_ctl.empty) state_in = q_item.zero_dir ? ST_OUT : ST_NLOAD;
         end
         ST_NLOAD: begin
            cnt_in   = '0;
            state_in = (mx_ld == '0) ? ST_OUT : ST_NSHIFT;
         end
         ST_NSHIFT: begin
            if (mx_ff[MAG_W-1:30] == '0 && mx_ff[29]) state_in = ST_SQ;
         end
         ST_SQ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2)) state_in = ST_SQWAIT;
         end
         ST_SQWAIT: begin
            state_in = ST_SQRT;
            cnt_in   = CNT_W'(31);
         end
         ST_SQRT: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIV;
               cnt_in   = CNT_W'(33);
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SCALE;
               cnt_in   = '0;
            end
         end
         ST_SCALE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2)) state_in = ST_SCWAIT;
         end
         ST_SCWAIT: begin
            cnt_in   = '0;
            state_in = pass_ff ? ST_CROSS2 : ST_CROSS1;
         end
         ST_CROSS1: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(5)) state_in = ST_CR1WAIT;
         end
         ST_CR1WAIT: state_in = ST_NLOAD;
         ST_CROSS2: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(14)) state_in = ST_CR2WAIT;
         end
         ST_CR2WAIT: begin
            state_in = ST_OUT;
            cnt_in   = '0;
         end
         ST_OUT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: queue pop and the multiply issued this cycle.
   always_comb begin
      q_pop    = (state_ff == ST_IDLE) && !q_ctl.empty;
      op_a     = '0;
      op_b     = '0;
      op_neg   = 1'b0;
      op_first = 1'b0;
      op_dest  = DST_NONE;
      unique case (state_ff)
         ST_SQ: begin
            op_a     = MUL_W'(m_ff[cnt_ff[1:0]][29:0]);
            op_b     = MUL_W'(m_ff[cnt_ff[1:0]][29:0]);
            op_first = (cnt_ff == '0);
            op_dest  = (cnt_ff == CNT_W'(2)) ? DST_SUMSQ : DST_NONE;
         end
         ST_SCALE: begin
            op_a     = MUL_W'(m_ff[cnt_ff[1:0]][29:0]);
            op_b     = MUL_W'(rec);
            op_first = 1'b1;
            case (cnt_ff[1:0])
               2'd0:    op_dest = DST_UNIT0;
               2'd1:    op_dest = DST_UNIT1;
               default: op_dest = DST_UNIT2;
            endcase
         end
         ST_CROSS1: begin
            case (cnt_ff)
               CNT_W'(0): begin op_a = ext_unit(f_ff[1]); op_b = ext_word(up_ff[2]);
                  op_first = 1'b1; end
               CNT_W'(1): begin op_a = ext_unit(f_ff[2]); op_b = ext_word(up_ff[1]);
                  op_neg = 1'b1; op_dest = DST_SR0; end
               CNT_W'(2): begin op_a = ext_unit(f_ff[2]); op_b = ext_word(up_ff[0]);
                  op_first = 1'b1; end
               CNT_W'(3): begin op_a = ext_unit(f_ff[0]); op_b = ext_word(up_ff[2]);
                  op_neg = 1'b1; op_dest = DST_SR1; end
               CNT_W'(4): begin op_a = ext_unit(f_ff[0]); op_b = ext_word(up_ff[1]);
                  op_first = 1'b1; end
               default: begin op_a = ext_unit(f_ff[1]); op_b = ext_word(up_ff[0]);
                  op_neg = 1'b1; op_dest = DST_SR2; end
            endcase
         end
         ST_CROSS2: begin
            case (cnt_ff)
               CNT_W'(0): begin op_a = ext_unit(s_ff[1]); op_b = ext_unit(f_ff[2]);
                  op_first = 1'b1; end
               CNT_W'(1): begin op_a = ext_unit(s_ff[2]); op_b = ext_unit(f_ff[1]);
                  op_neg = 1'b1; op_dest = DST_U0; end
               CNT_W'(2): begin op_a = ext_unit(s_ff[2]); op_b = ext_unit(f_ff[0]);
                  op_first = 1'b1; end
               CNT_W'(3): begin op_a = ext_unit(s_ff[0]); op_b = ext_unit(f_ff[2]);
                  op_neg = 1'b1; op_dest = DST_U1; end
               CNT_W'(4): begin op_a = ext_unit(s_ff[0]); op_b = ext_unit(f_ff[1]);
                  op_first = 1'b1; end
               CNT_W'(5): begin op_a = ext_unit(s_ff[1]); op_b = ext_unit(f_ff[0]);
                  op_neg = 1'b1; op_dest = DST_U2; end
               CNT_W'(6): begin op_a = ext_unit(s_ff[0]); op_b = ext_word(eye_ff[0]);
                  op_first = 1'b1; end
               CNT_W'(7): begin op_a = ext_unit(s_ff[1]); op_b = ext_word(eye_ff[1]); end
               CNT_W'(8): begin op_a = ext_unit(s_ff[2]); op_b = ext_word(eye_ff[2]);
                  op_dest = DST_TS; end
               CNT_W'(9): begin op_a = ext_unit(f_ff[0]); op_b = ext_word(eye_ff[0]);
                  op_first = 1'b1; end
               CNT_W'(10): begin op_a = ext_unit(f_ff[1]); op_b = ext_word(eye_ff[1]); end
               CNT_W'(11): begin op_a = ext_unit(f_ff[2]); op_b = ext_word(eye_ff[2]);
                  op_dest = DST_TF; end
               CNT_W'(12): begin op_a = ext_unit(u_ff[0]); op_b = ext_word(eye_ff[0]);
                  op_first = 1'b1; end
               CNT_W'(13): begin op_a = ext_unit(u_ff[1]); op_b = ext_word(eye_ff[1]); end
               default: begin op_a = ext_unit(u_ff[2]); op_b = ext_word(eye_ff[2]);
                  op_dest = DST_TU; end
            endcase
         end
         default: op_dest = DST_NONE;
      endcase
   end

   // Accumulate stage and unit-component rounding.
   always_comb begin
      acc_sum  = (p_first_ff ? PROD_W'(0) : acc_ff) + (p_neg_ff ? -prod_ff : prod_ff);
      unit_tmp = acc_sum + (PROD_W'(1) <<< 44);
      unit_q   = unit_tmp[64:45];
      col      = cnt_ff[1:0];
      unit_v   = $signed(unit_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rsp_strobe <= 1'b0;
         p_dest_ff  <= DST_NONE;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rsp_strobe <= (state_ff == ST_OUT);
         p_dest_ff  <= op_dest;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= op_a * op_b;
      p_first_ff <= op_first;
      p_neg_ff   <= op_neg;
      acc_ff     <= acc_sum;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               for (int i = 0; i < 3; i++) begin
                  eye_ff[i] <= $signed(q_item.eye[i]);
                  d_ff[i]   <= $signed(q_item.dir[i]);
                  up_ff[i]  <= $signed(q_item.up[i]);
               end
               pass_ff  <= 1'b0;
               degen_ff <= q_item.zero_dir;
            end
         end
         ST_NLOAD: begin
            for (int i = 0; i < 3; i++) begin
               m_ff[i]   <= mag_ld[i];
               neg_ff[i] <= vsel[i][SR_W-1];
            end
            mx_ff <= mx_ld;
            if (mx_ld == '0) degen_ff <= 1'b1;
         end
         ST_NSHIFT: begin
            if (mx_ff[MAG_W-1:30] != '0) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               mx_ff <= mx_ff >> 1;
            end else if (!mx_ff[29]) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
               mx_ff <= mx_ff << 1;
            end
         end
         ST_SQ: r_ff <= '0;
         ST_SQRT: begin
            if (63'(x_ff) >= sq_try) begin
               x_ff <= x_ff - sq_try[61:0];
               r_ff <= (r_ff >> 1) + sq_bit;
            end else begin
               r_ff <= r_ff >> 1;
            end
            rem_ff <= 32'd1 << 28;
            q_ff   <= '0;
         end
         ST_DIV: begin
            if (div_try >= 33'(r_ff[30:0])) begin
               rem_ff <= 32'(div_try - 33'(r_ff[30:0]));
               q_ff   <= {q_ff[32:0], 1'b1};
            end else begin
               rem_ff <= div_try[31:0];
               q_ff   <= {q_ff[32:0], 1'b0};
            end
         end
         ST_CR1WAIT: pass_ff <= 1'b1;
         default: ;
      endcase

      // Write-back of finished accumulations.
      case (p_dest_ff)
         DST_SUMSQ: x_ff <= acc_sum[61:0];
         DST_UNIT0: begin
            if (pass_ff) s_ff[0] <= neg_ff[0] ? -unit_v : unit_v;
            else         f_ff[0] <= neg_ff[0] ? -unit_v : unit_v;
         end
         DST_UNIT1: begin
            if (pass_ff) s_ff[1] <= neg_ff[1] ? -unit_v : unit_v;
            else         f_ff[1] <= neg_ff[1] ? -unit_v : unit_v;
         end
         DST_UNIT2: begin
            if (pass_ff) s_ff[2] <= neg_ff[2] ? -unit_v : unit_v;
            else         f_ff[2] <= neg_ff[2] ? -unit_v : unit_v;
         end
         DST_SR0: sr_ff[0] <= acc_sum[SR_W-1:0];
         DST_SR1: sr_ff[1] <= acc_sum[SR_W-1:0];
         DST_SR2: sr_ff[2] <= acc_sum[SR_W-1:0];
         DST_U0:  u_ff[0]  <= UNIT_W'(rnd16(acc_sum));
         DST_U1:  u_ff[1]  <= UNIT_W'(rnd16(acc_sum));
         DST_U2:  u_ff[2]  <= UNIT_W'(rnd16(acc_sum));
         DST_TS:  ts_ff    <= -rnd16(acc_sum);
         DST_TF:  tf_ff    <= rnd16(acc_sum);
         DST_TU:  tu_ff    <= -rnd16(acc_sum);
         default: ;
      endcase

      // Result registers, one column per cycle.
      rsp_column_index <= col;
      rsp_degenerate   <= degen_ff;
      rsp_last_column  <= (col == 2'd3);
      if (degen_ff) begin
         rsp_row0 <= (col == 2'd0) ? ONE_Q16 : '0;
         rsp_row1 <= (col == 2'd1) ? ONE_Q16 : '0;
         rsp_row2 <= (col == 2'd2) ? ONE_Q16 : '0;
         rsp_row3 <= (col == 2'd3) ? ONE_Q16 : '0;
      end else if (col == 2'd3) begin
         rsp_row0 <= sat32(ts_ff);
         rsp_row1 <= sat32(tu_ff);
         rsp_row2 <= sat32(tf_ff);
         rsp_row3 <= ONE_Q16;
      end else begin
         rsp_row0 <= WORD_W'(s_ff[col]);
         rsp_row1 <= WORD_W'(u_ff[col]);
         rsp_row2 <= -WORD_W'(f_ff[col]);
         rsp_row3 <= '0;
      end
   end

endmodule
`default_nettype wire

@@ rtl/look_at_view_matrix.sv @@
// Top level of the look-at view matrix block: front, item queue and back part.
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_*           item taken when start is high and busy is low
//   result    rsp_strobe, rsp_*            one column per strobe cycle, four per item
//
// In the back part, each of the two normalizations of an item runs a
// one-bit-a-cycle alignment shift, a 32-step square root and a 34-step
// restoring divider, followed by three shared-multiplier passes; the cross
// products and dot products then run on the shared multiplier and the four
// columns leave back to back. An item with center equal to eye skips straight
// to the identity. The front and the two-entry queue keep taking items while
// the back part works; busy is high only while the queue is full. Reset is
// synchronous and empties the queue and returns the sequencer to idle. The
// receiver cannot stall: every strobe delivers a column.
`default_nettype none
module look_at_view_matrix (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_eye_x,
   input  wire logic signed [31:0] req_eye_y,
   input  wire logic signed [31:0] req_eye_z,
   input  wire logic signed [31:0] req_center_x,
   input  wire logic signed [31:0] req_center_y,
   input  wire logic signed [31:0] req_center_z,
   input  wire logic signed [31:0] req_up_x,
   input  wire logic signed [31:0] req_up_y,
   input  wire logic signed [31:0] req_up_z,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_column_index,
   output logic signed [31:0]      rsp_row0,
   output logic signed [31:0]      rsp_row1,
   output logic signed [31:0]      rsp_row2,
   output logic signed [31:0]      rsp_row3,
   output logic                    rsp_degenerate,
   output logic                    rsp_last_column
);
   import lavm_pkg::*;

   lavm_qin_type  push_ctl;
   lavm_qout_type pop_ctl;
   lavm_item_type front_item, queue_item;
   logic          q_full, q_pop;

   // The front forms the view direction and flags the zero-direction case.
   lavm_front u_front (
      .start        (start),
      .busy         (busy),
      .req_eye_x    (req_eye_x),
      .req_eye_y    (req_eye_y),
      .req_eye_z    (req_eye_z),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_up_x     (req_up_x),
      .req_up_y     (req_up_y),
      .req_up_z     (req_up_z),
      .q_full       (q_full),
      .q_ctl        (push_ctl),
      .q_item       (front_item)
   );

   // The queue decouples request acceptance from the long back-end sequence.
   lavm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (push_ctl),
      .in_item  (front_item),
      .full     (q_full),
      .pop      (q_pop),
      .out_ctl  (pop_ctl),
      .out_item (queue_item)
   );

   // The back part normalizes, builds the basis and emits the four columns.
   lavm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_ctl            (pop_ctl),
      .q_item           (queue_item),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_column_index (rsp_column_index),
      .rsp_row0         (rsp_row0),
      .rsp_row1         (rsp_row1),
      .rsp_row2         (rsp_row2),
      .rsp_row3         (rsp_row3),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_last_column  (rsp_last_column)
   );

endmodule
`default_nettype wire

@@ test/lavm_view_checker.sv @@
// Checker for the look-at view matrix block: predicts each item's four columns and compares.
module lavm_view_checker
   import lavm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic signed [31:0] req_up_x,
   input  logic signed [31:0] req_up_y,
   input  logic signed [31:0] req_up_z,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_column_index,
   input  logic signed [31:0] rsp_row0,
   input  logic signed [31:0] rsp_row1,
   input  logic signed [31:0] rsp_row2,
   input  logic signed [31:0] rsp_row3,
   input  logic               rsp_degenerate,
   input  logic               rsp_last_column,
   output int                 failures,
   output int                 columns_pending
);

   typedef struct {
      logic [1:0]         index;
      logic signed [31:0] row [4];
      logic               degen;
      logic               last;
   } view_column_t;

   view_column_t expected_columns [$];

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint signed_as(input longint ref_v, input longint unsigned m);
      return (ref_v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint round_to_q16(input longint v);
      return signed_as(v, (magnitude(v) + 64'h8000) >> 16);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Unit vector in Q16.16; returns 0 for the zero vector.
   function automatic bit unit_vector(input longint v [3], output longint o [3]);
      longint unsigned m [3];
      longint unsigned mx, sum, len, rec, q;
      int rsh, lsh;
      mx = 0; sum = 0; rsh = 0; lsh = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > mx) mx = m[i];
         o[i] = 0;
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin mx = mx >> 1; rsh++; end
      while (mx < (64'd1 << 29)) begin mx = mx << 1; lsh++; end
      for (int i = 0; i < 3; i++) begin
         m[i] = (rsh != 0) ? (m[i] >> rsh) : (m[i] << lsh);
         sum = sum + m[i] * m[i];
      end
      len = int_sqrt(sum);
      rec = ((64'd1 << 62) / len + 1) >> 1;
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * rec + (64'd1 << 44)) >> 45;
         o[i] = signed_as(v[i], q);
      end
      return 1;
   endfunction

   task automatic predict_view_matrix();
      longint eye [3], up [3], dir [3], fwd [3], side_raw [3], side [3], upv [3];
      longint col [4][4];
      bit     ok;
      view_column_t c;
      eye = '{longint'(req_eye_x), longint'(req_eye_y), longint'(req_eye_z)};
      up  = '{longint'(req_up_x), longint'(req_up_y), longint'(req_up_z)};
      dir = '{longint'(req_center_x) - eye[0], longint'(req_center_y) - eye[1],
              longint'(req_center_z) - eye[2]};
      ok = unit_vector(dir, fwd);
      if (ok) begin
         side_raw[0] = fwd[1] * up[2] - fwd[2] * up[1];
         side_raw[1] = fwd[2] * up[0] - fwd[0] * up[2];
         side_raw[2] = fwd[0] * up[1] - fwd[1] * up[0];
         ok = unit_vector(side_raw, side);
      end
      if (ok) begin
         upv[0] = round_to_q16(side[1] * fwd[2] - side[2] * fwd[1]);
         upv[1] = round_to_q16(side[2] * fwd[0] - side[0] * fwd[2]);
         upv[2] = round_to_q16(side[0] * fwd[1] - side[1] * fwd[0]);
         for (int k = 0; k < 3; k++) col[k] = '{side[k], upv[k], -fwd[k], 0};
         col[3][0] = -round_to_q16(side[0] * eye[0] + side[1] * eye[1] + side[2] * eye[2]);
         col[3][1] = -round_to_q16(upv[0] * eye[0] + upv[1] * eye[1] + upv[2] * eye[2]);
         col[3][2] = round_to_q16(fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2]);
         col[3][3] = ONE_Q16;
      end else begin
         for (int k = 0; k < 4; k++)
            for (int r = 0; r < 4; r++) col[k][r] = (k == r) ? longint'(ONE_Q16) : 0;
      end
      for (int k = 0; k < 4; k++) begin
         c.index = k[1:0];
         for (int r = 0; r < 4; r++) c.row[r] = clamp32(col[k][r]);
         c.degen = !ok;
         c.last  = (k == 3);
         expected_columns.push_back(c);
      end
   endtask

   // Mismatches of one column are counted locally and added in one update.
   always @(posedge clock) begin
      view_column_t e;
      logic signed [31:0] got [4];
      int errs;
      errs = 0;
      if (reset) begin
         expected_columns.delete();
         failures <= 0;
      end else begin
         if (start && !busy) predict_view_matrix();
         if (rsp_strobe) begin
            if (expected_columns.size() == 0) begin
               $error("column arrived with no item outstanding");
               errs++;
            end else begin
               e = expected_columns.pop_front();
               got = '{rsp_row0, rsp_row1, rsp_row2, rsp_row3};
               if (rsp_column_index !== e.index) begin
                  $error("column_index: expected %0d, actual %0d", e.index, rsp_column_index);
                  errs++;
               end
               for (int r = 0; r < 4; r++)
                  if (got[r] !== e.row[r]) begin
                     $error("row%0d: expected %0d, actual %0d", r, e.row[r], got[r]);
                     errs++;
                  end
               if (rsp_degenerate !== e.degen) begin
                  $error("degenerate: expected %0d, actual %0d", e.degen, rsp_degenerate);
                  errs++;
               end
               if (rsp_last_column !== e.last) begin
                  $error("last_column: expected %0d, actual %0d", e.last, rsp_last_column);
                  errs++;
               end
            end
         end
         failures <= failures + errs;
      end
      columns_pending <= expected_columns.size();
   end

endmodule

@@ test/tb_look_at_view_matrix.sv @@
// Testbench top for the look-at view matrix block: clock, reset, stimulus and verdict.
module tb_look_at_view_matrix;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
   logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
   logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
   logic               rsp_strobe;
   logic [1:0]         rsp_column_index;
   logic signed [31:0] rsp_row0, rsp_row1, rsp_row2, rsp_row3;
   logic               rsp_degenerate, rsp_last_column;
   int                 failures;
   int                 columns_pending;

   localparam logic signed [31:0] MAX_Q = 32'sh7fffffff;
   localparam logic signed [31:0] MIN_Q = 32'sh80000000;
   localparam logic signed [31:0] ONE   = 32'sd65536;

   always #4 clock = ~clock;

   look_at_view_matrix u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(eye_x), .req_eye_y(eye_y), .req_eye_z(eye_z),
      .req_center_x(center_x), .req_center_y(center_y), .req_center_z(center_z),
      .req_up_x(up_x), .req_up_y(up_y), .req_up_z(up_z),
      .rsp_strobe(rsp_strobe), .rsp_column_index(rsp_column_index),
      .rsp_row0(rsp_row0), .rsp_row1(rsp_row1), .rsp_row2(rsp_row2), .rsp_row3(rsp_row3),
      .rsp_degenerate(rsp_degenerate), .rsp_last_column(rsp_last_column)
   );

   lavm_view_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(eye_x), .req_eye_y(eye_y), .req_eye_z(eye_z),
      .req_center_x(center_x), .req_center_y(center_y), .req_center_z(center_z),
      .req_up_x(up_x), .req_up_y(up_y), .req_up_z(up_z),
      .rsp_strobe(rsp_strobe), .rsp_column_index(rsp_column_index),
      .rsp_row0(rsp_row0), .rsp_row1(rsp_row1), .rsp_row2(rsp_row2), .rsp_row3(rsp_row3),
      .rsp_degenerate(rsp_degenerate), .rsp_last_column(rsp_last_column),
      .failures(failures), .columns_pending(columns_pending)
   );

   // Presents one item and holds it until the block takes it. The caller is
   // at a rising edge; start stays high so back-to-back items need no gap.
   task automatic send_item(input logic signed [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz);
      start    <= 1'b1;
      eye_x    <= ex; eye_y    <= ey; eye_z    <= ez;
      center_x <= cx; center_y <= cy; center_z <= cz;
      up_x     <= ux; up_y     <= uy; up_z     <= uz;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Most gaps are zero or short; a few are long enough for the block to
   // drain completely, so items also arrive while it is fully idle.
   task automatic sender_gap();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: n = 0;
         4, 5, 6, 7: n = $urandom_range(1, 6);
         8:          n = $urandom_range(20, 120);
         default:    n = $urandom_range(200, 600);
      endcase
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // A coordinate: full-range words exercise every bit and saturation, small
   // ones the low bits; the rest are scene-sized and keep the geometry well conditioned.
   function automatic logic signed [31:0] coordinate();
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return ($urandom_range(0, 1) != 0) ? MAX_Q : MIN_Q;
         2:       return $signed($urandom_range(0, 32)) - 16;
         default: return $signed($urandom_range(0, 2 * 100 * 65536)) - 100 * 65536;
      endcase
   endfunction

   initial begin
      logic signed [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz;
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: zero view direction, up of zero length, up parallel
      // to the view, ordinary cameras, and the extremes of every field.
      send_item(0, 0, 0, 0, 0, 0, 0, ONE, 0);
      send_item(ONE, -ONE, 3 * ONE, ONE, -ONE, 3 * ONE, 0, ONE, 0);
      send_item(0, 0, 5 * ONE, 0, 0, 0, 0, 0, 0);
      send_item(0, 0, 5 * ONE, 0, 0, 0, 0, 0, -7 * ONE);
      send_item(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
      send_item(3 * ONE, 2 * ONE, 4 * ONE, 0, ONE, 0, 0, ONE, 0);
      send_item(MAX_Q, MAX_Q, MAX_Q, MIN_Q, MIN_Q, MIN_Q, 0, ONE, 0);
      send_item(MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MIN_Q, 0);
      send_item(MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q);
      send_item(MAX_Q, 0, 0, MAX_Q, 1, 0, MAX_Q, MAX_Q, MAX_Q);
      send_item(-1, 0, 0, 0, 0, 1, 1, 0, 0);
      send_item(MIN_Q, MAX_Q, -1, -1, -1, -1, 0, 1, 0);
      send_item(32'sh55555555, 32'shAAAAAAAA, 0, 0, 0, 0, 32'sh55555555, 0, 32'shAAAAAAAA);
      send_item(10 * ONE, 0, 0, 0, 0, 0, -3 * ONE, 0, 0);
      sender_gap();

      // Random items. Most are valid cameras; a few repeat the eye as the
      // center, zero the up vector or make up parallel to the view direction.
      for (int i = 0; i < 320; i++) begin
         ex = coordinate(); ey = coordinate(); ez = coordinate();
         cx = coordinate(); cy = coordinate(); cz = coordinate();
         ux = coordinate(); uy = coordinate(); uz = coordinate();
         k = $urandom_range(0, 19);
         if (k == 0) begin
            cx = ex; cy = ey; cz = ez;
         end else if (k == 1) begin
            ux = 0; uy = 0; uz = 0;
         end else if (k == 2) begin
            cx = ex + 2 * ONE; cy = ey; cz = ez;
            ux = -ONE; uy = 0; uz = 0;
         end
         send_item(ex, ey, ez, cx, cy, cz, ux, uy, uz);
         sender_gap();
      end
      start <= 1'b0;

      @(posedge clock);
      while (columns_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (failures == 0) begin
         $display("look_at_view_matrix test passed");
      end else begin
         $display("look_at_view_matrix test failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #20000000;
      $display("look_at_view_matrix test failed");
      $finish;
   end

endmodule
